>>> hdl/lptd_pkg.sv
// Shared types, constants and functions for the laser plane triangulation depth block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lptd_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned DIV_STEPS    = 32;

  localparam logic signed [33:0] GAIN_INV     = 34'sd652032874;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd23040;
  localparam logic signed [16:0] HALF_TURN    = 17'sd46080;

  // Configuration register indexes.
  localparam logic [2:0] REG_TILT     = 3'd0;
  localparam logic [2:0] REG_BASELINE = 3'd1;
  localparam logic [2:0] REG_FOCAL    = 3'd2;
  localparam logic [2:0] REG_CX       = 3'd3;
  localparam logic [2:0] REG_CY       = 3'd4;

  // Rotation state of one CORDIC lane: cos and sin in Q30, residual angle
  // in units of 2^-24 degree, and the fold flag.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic               flip;
  } cordic_t;

  // Partial remainder, remaining dividend bits, quotient and divisor.
  typedef struct packed {
    logic [54:0] r;
    logic [31:0] p;
    logic [31:0] q;
    logic [54:0] d;
  } div_t;

  function automatic logic signed [32:0] atan_units(input logic [4:0] step);
    logic signed [32:0] v;
    case (step)
      5'd0:    v = 33'sd754974720;
      5'd1:    v = 33'sd445687602;
      5'd2:    v = 33'sd235489088;
      5'd3:    v = 33'sd119537938;
      5'd4:    v = 33'sd60000934;
      5'd5:    v = 33'sd30029717;
      5'd6:    v = 33'sd15018523;
      5'd7:    v = 33'sd7509720;
      5'd8:    v = 33'sd3754917;
      5'd9:    v = 33'sd1877466;
      5'd10:   v = 33'sd938734;
      5'd11:   v = 33'sd469367;
      5'd12:   v = 33'sd234684;
      5'd13:   v = 33'sd117342;
      5'd14:   v = 33'sd58671;
      5'd15:   v = 33'sd29335;
      5'd16:   v = 33'sd14668;
      5'd17:   v = 33'sd7334;
      5'd18:   v = 33'sd3667;
      5'd19:   v = 33'sd1833;
      5'd20:   v = 33'sd917;
      5'd21:   v = 33'sd458;
      5'd22:   v = 33'sd229;
      5'd23:   v = 33'sd115;
      5'd24:   v = 33'sd57;
      5'd25:   v = 33'sd29;
      5'd26:   v = 33'sd14;
      5'd27:   v = 33'sd7;
      5'd28:   v = 33'sd4;
      5'd29:   v = 33'sd2;
      5'd30:   v = 33'sd1;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

  // Folds an angle into +-90 degrees and builds the CORDIC start vector.
  function automatic cordic_t cordic_start(input logic signed [15:0] ang);
    cordic_t            c;
    logic signed [16:0] a;
    a = 17'(ang);
    c.flip = 1'b0;
    if (a > QUARTER_TURN) begin
      a = a - HALF_TURN;
      c.flip = 1'b1;
    end else if (a < -QUARTER_TURN) begin
      a = a + HALF_TURN;
      c.flip = 1'b1;
    end
    c.x = GAIN_INV;
    c.y = '0;
    c.z = {a, 16'b0};
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/lptd_cordic_cell.sv
// One rotation step of the sine/cosine CORDIC row, registered at its output.
// Depends on lptd_pkg for the lane type and the arctangent table.
`default_nettype none

module lptd_cordic_cell (
  input  wire logic             clk_i,
  input  wire logic [4:0]       step_i,
  input  wire lptd_pkg::cordic_t cell_i,
  output lptd_pkg::cordic_t     cell_o
);
  import lptd_pkg::*;

  cordic_t            cell_d;
  cordic_t            cell_q;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [32:0] at;

  always_comb begin
    xs = cell_i.x >>> step_i;
    ys = cell_i.y >>> step_i;
    at = atan_units(step_i);
    cell_d = cell_i;
    if (cell_i.z >= 0) begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - at;
    end else begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

>>> hdl/lptd_div_cell.sv
// One restoring-division step: shifts in a dividend bit and retires one quotient bit.
// Depends on lptd_pkg for the division stage type.
`default_nettype none

module lptd_div_cell (
  input  wire logic          clk_i,
  input  wire lptd_pkg::div_t cell_i,
  output lptd_pkg::div_t     cell_o
);
  import lptd_pkg::*;

  div_t        cell_d;
  div_t        cell_q;
  logic [55:0] rs;
  logic [55:0] rn;
  logic        ge;

  always_comb begin
    rs = {cell_i.r, cell_i.p[31]};
    ge = rs >= {1'b0, cell_i.d};
    rn = ge ? rs - {1'b0, cell_i.d} : rs;
    cell_d.r = rn[54:0];
    cell_d.p = {cell_i.p[30:0], 1'b0};
    cell_d.q = {cell_i.q[30:0], ge};
    cell_d.d = cell_i.d;
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

>>> hdl/laser_plane_triangulation_depth.sv
// Top level of the laser plane triangulation depth pipeline.
// Depends on lptd_pkg, lptd_cordic_cell and lptd_div_cell.
// Throughput: one pixel per clock; busy is never raised and the receiver cannot stall.
// The result strobe done_o follows the transfer through the input stage, the
// CORDIC row, the arithmetic stages A to E, the 32-cell division row and the
// output register. Reset clears the pipeline valid flags and loads the register
// defaults; results in flight are dropped.
`default_nettype none

module laser_plane_triangulation_depth (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic signed [15:0] laser_angle_i,
  input  wire logic [15:0] pixel_column_i,
  input  wire logic [15:0] pixel_row_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [19:0] cfg_data_i,
  output logic             done_o,
  output logic [31:0]      depth_o,
  output logic             depth_valid_o
);
  import lptd_pkg::*;

  // Configuration registers. The user must change them only while the pipeline
  // is empty; the block does not enforce this, and every stage reads them directly.
  logic signed [15:0] tilt_q;
  logic [15:0]        baseline_q;
  logic [19:0]        focal_q;
  logic [15:0]        cx_q;
  logic [15:0]        cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_q     <= '0;
      baseline_q <= '0;
      focal_q    <= 20'd4096;
      cx_q       <= '0;
      cy_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TILT:     tilt_q     <= cfg_data_i[15:0];
        REG_BASELINE: baseline_q <= cfg_data_i[15:0];
        REG_FOCAL:    focal_q    <= cfg_data_i;
        REG_CX:       cx_q       <= cfg_data_i[15:0];
        REG_CY:       cy_q       <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // The pipeline never pushes back.
  assign busy = 1'b0;

  // Valid flags for every register stage, in order: the input stage, the
  // CORDIC row, the five arithmetic stages, the division row and the output
  // register.
  localparam int unsigned CS = CORDIC_STEPS;
  localparam int unsigned LAST = CS + 6 + DIV_STEPS;

  logic [LAST:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAST-1:0], start & ~busy};
    end
  end

  // Input stage: fold both angles and offset the pixel by the principal point.
  cordic_t            phi_c [CS+1];
  cordic_t            th_c  [CS+1];
  logic signed [16:0] xo_q  [CS+1];
  logic signed [16:0] yo_q  [CS+1];

  always_ff @(posedge clk_i) begin
    phi_c[0] <= cordic_start(laser_angle_i);
    th_c[0]  <= cordic_start(tilt_q);
    xo_q[0]  <= $signed({1'b0, pixel_column_i}) - $signed({1'b0, cx_q});
    yo_q[0]  <= $signed({1'b0, pixel_row_i}) - $signed({1'b0, cy_q});
  end

  // CORDIC row: two lanes per step, phi for the item and theta for the tilt.
  for (genvar k = 0; k < CS; k++) begin : g_cordic
    lptd_cordic_cell u_phi (
      .clk_i  (clk_i),
      .step_i (5'(k)),
      .cell_i (phi_c[k]),
      .cell_o (phi_c[k+1])
    );
    lptd_cordic_cell u_th (
      .clk_i  (clk_i),
      .step_i (5'(k)),
      .cell_i (th_c[k]),
      .cell_o (th_c[k+1])
    );
    always_ff @(posedge clk_i) begin
      xo_q[k+1] <= xo_q[k];
      yo_q[k+1] <= yo_q[k];
    end
  end

  // Apply the fold sign. Sine and cosine stay within about 2^30, so 32 bits
  // hold them.
  logic signed [33:0] cp_w, sp_w, ct_w, st_w;
  logic signed [31:0] cp, sp, ct, st;

  always_comb begin
    cp_w = phi_c[CS].flip ? -phi_c[CS].x : phi_c[CS].x;
    sp_w = phi_c[CS].flip ? -phi_c[CS].y : phi_c[CS].y;
    ct_w = th_c[CS].flip ? -th_c[CS].x : th_c[CS].x;
    st_w = th_c[CS].flip ? -th_c[CS].y : th_c[CS].y;
    cp = cp_w[31:0];
    sp = sp_w[31:0];
    ct = ct_w[31:0];
    st = st_w[31:0];
  end

  // Stage A: angle products and the sin(phi)*y term.
  logic signed [63:0] pcc_q, pcs_q;
  logic signed [48:0] spy_a_q;
  logic signed [16:0] xo_a_q;

  always_ff @(posedge clk_i) begin
    pcc_q   <= cp * ct;
    pcs_q   <= cp * st;
    spy_a_q <= sp * yo_q[CS];
    xo_a_q  <= xo_q[CS];
  end

  // Stage B: take the angle products back to Q30 and scale by f and x.
  logic signed [31:0] cc, cs;
  logic signed [20:0] fs;
  logic signed [52:0] csf_q, ccf_q;
  logic signed [48:0] ccx_q, spy_b_q;

  always_comb begin
    cc = 32'(pcc_q >>> 30);
    cs = 32'(pcs_q >>> 30);
    fs = $signed({1'b0, focal_q});
  end

  always_ff @(posedge clk_i) begin
    csf_q   <= cs * fs;
    ccf_q   <= cc * fs;
    ccx_q   <= cc * xo_a_q;
    spy_b_q <= spy_a_q;
  end

  // Stage C: exact denominator and numerator, both Q30.
  logic signed [54:0] den_q;
  logic signed [52:0] num_q;

  always_ff @(posedge clk_i) begin
    den_q <= 55'(csf_q) - 55'(ccx_q) - 55'(spy_b_q);
    num_q <= ccf_q;
  end

  // Stage D: magnitudes, parallel-ray flag, baseline times |N| in two halves.
  logic [54:0] magd_w;
  logic [52:0] magn_w;
  logic [54:0] magd_q;
  logic        dz_d_q;
  logic [41:0] plo_q, phi_q;

  always_comb begin
    magd_w = den_q[54] ? 55'(-den_q) : den_q;
    magn_w = num_q[52] ? 53'(-num_q) : num_q;
  end

  always_ff @(posedge clk_i) begin
    magd_q <= magd_w;
    dz_d_q <= den_q == '0;
    plo_q  <= baseline_q * magn_w[25:0];
    phi_q  <= baseline_q * magn_w[51:26];
  end

  // Stage E: full product, overflow test and division start.
  logic [67:0] prod_w;
  div_t        dv [DIV_STEPS+1];
  logic        ovf_q [DIV_STEPS+1];
  logic        dz_q  [DIV_STEPS+1];

  assign prod_w = ({26'b0, phi_q} << 26) + {26'b0, plo_q};

  always_ff @(posedge clk_i) begin
    ovf_q[0] <= {19'b0, prod_w} >= {magd_q, 32'b0};
    dz_q[0]  <= dz_d_q;
    dv[0].r  <= {19'b0, prod_w[67:32]};
    dv[0].p  <= prod_w[31:0];
    dv[0].q  <= '0;
    dv[0].d  <= magd_q;
  end

  // Division row: one quotient bit per cell.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    lptd_div_cell u_div (
      .clk_i  (clk_i),
      .cell_i (dv[k]),
      .cell_o (dv[k+1])
    );
    always_ff @(posedge clk_i) begin
      ovf_q[k+1] <= ovf_q[k];
      dz_q[k+1]  <= dz_q[k];
    end
  end

  // Output register: a parallel ray reads zero and invalid, an oversized
  // quotient saturates.
  logic [31:0] depth_q;
  logic        dvalid_q;

  always_ff @(posedge clk_i) begin
    if (dz_q[DIV_STEPS]) begin
      depth_q  <= '0;
      dvalid_q <= 1'b0;
    end else begin
      depth_q  <= ovf_q[DIV_STEPS] ? '1 : dv[DIV_STEPS].q;
      dvalid_q <= 1'b1;
    end
  end

  assign done_o        = vld_q[LAST];
  assign depth_o       = depth_q;
  assign depth_valid_o = dvalid_q;

  // An invalid result always carries zero depth.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !depth_valid_o |-> depth_o == '0)
    else $error("invalid result with nonzero depth");

  // A zero baseline can only give zero depth.
  a_zero_baseline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && baseline_q == '0 |-> depth_o == '0)
    else $error("nonzero depth with zero baseline");

  // A zero focal length makes the numerator vanish.
  a_zero_focal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && focal_q == '0 |-> depth_o == '0)
    else $error("nonzero depth with zero focal length");

endmodule

`default_nettype wire
